[hw/rtl/assert_macros.svh]
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the batch commit tracker checkers.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, held off while reset is asserted
`define FBCT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset
`define FBCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/fbct_pkg.sv]
// -----------------------------------------------------------------------------
// fbct_pkg
// Types and constants shared by the batch commit tracker and its checker.
// -----------------------------------------------------------------------------
package fbct_pkg;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_FIELD    = 2'd0,
        FUNC_POLL     = 2'd1,
        FUNC_FULL_RST = 2'd2,
        FUNC_DISC_RST = 2'd3
    } func_t;

    // Field kinds
    localparam logic [1:0] KIND_TITLE = 2'd0;
    localparam logic [1:0] KIND_BODY  = 2'd1;
    localparam logic [1:0] KIND_TAG   = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // Resolution codes
    typedef enum logic [1:0] {
        RES_NONE    = 2'd0,
        RES_COMMIT  = 2'd1,
        RES_DISCARD = 2'd2
    } res_code_t;

    localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

    // One poll result
    typedef struct packed {
        logic [1:0]  resolution;
        logic        timed_out;
        logic [7:0]  batch_id;
        logic        elapsed_valid;
        logic [31:0] elapsed_ms;
        logic        has_title;
        logic        has_body;
        logic        has_tag_state;
        logic        tag_in_batch;
    } result_t;

    // Batch tracking state
    typedef struct packed {
        logic        title_present;
        logic        body_present;
        logic        commit_pending;
        logic        batch_poisoned;
        logic [31:0] start_time;
        logic [7:0]  held_batch_id;
        logic        tag_pending;
        logic        tag_rode_batch;
    } batch_state_t;

endpackage

[hw/rtl/field_batch_commit_tracker_core.sv]
// -----------------------------------------------------------------------------
// field_batch_commit_tracker_core
// Tracks a batch of received message fields and resolves it on poll.
//
//   channel   direction  handshake              payload
//   in        request    in_valid / in_ready    func, field_kind, last_field,
//                                               dropped, push_id, now_ms
//   out       result     out_valid / out_ready  resolution ... tag_in_batch
//   cfg       write      cfg_valid / cfg_ready  cfg_data (timeout_ms)
//
// A request is registered into the stage and evaluated combinationally
// against the batch state; a poll loads the result register as it leaves.
// One request per cycle is sustained; the stage stalls only when a poll
// meets a full result register that is not being taken.
// Field events and resets produce no result. cfg is always ready.
// Reset clears batch state and loads timeout_ms with 5000.
// -----------------------------------------------------------------------------
module field_batch_commit_tracker_core
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [1:0]  field_kind,
    input  logic        last_field,
    input  logic        dropped,
    input  logic [7:0]  push_id,
    input  logic [31:0] now_ms,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  resolution,
    output logic        timed_out,
    output logic [7:0]  batch_id,
    output logic        elapsed_valid,
    output logic [31:0] elapsed_ms,
    output logic        has_title,
    output logic        has_body,
    output logic        has_tag_state,
    output logic        tag_in_batch,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import fbct_pkg::*;

    logic         stg_valid_reg;
    logic [1:0]   stg_func_reg;
    logic [1:0]   stg_kind_reg;
    logic         stg_last_reg;
    logic         stg_drop_reg;
    logic [7:0]   stg_id_reg;
    logic [31:0]  stg_now_reg;

    logic [31:0]  timeout_reg;
    batch_state_t st_reg, st_next;
    logic         out_valid_reg;
    result_t      res_reg, res_next;

    logic         out_free;
    logic         stg_go;
    logic         stg_is_poll;

    logic [31:0]  diff;
    logic         batch_open;
    logic         batch_idle;
    logic         is_text;
    logic         tmo_hit;
    logic         go;

    // Handshake chain: result slot, evaluation stage, input
    assign out_free    = !out_valid_reg || out_ready;
    assign stg_is_poll = (stg_func_reg == FUNC_POLL);
    assign stg_go      = stg_valid_reg && (!stg_is_poll || out_free);
    assign in_ready    = !stg_valid_reg || stg_go;
    assign cfg_ready   = 1'b1;

    // Hold the timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // Capture the request into the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_func_reg <= func;
            stg_kind_reg <= field_kind;
            stg_last_reg <= last_field;
            stg_drop_reg <= dropped;
            stg_id_reg   <= push_id;
            stg_now_reg  <= now_ms;
        end
    end

    // Evaluate the staged request against the batch state
    assign diff       = stg_now_reg - st_reg.start_time;
    assign batch_open = st_reg.title_present || st_reg.body_present
                        || st_reg.batch_poisoned;
    assign batch_idle = !batch_open;
    assign is_text    = (stg_kind_reg == KIND_TITLE) || (stg_kind_reg == KIND_BODY);
    assign tmo_hit    = !st_reg.commit_pending && batch_open
                        && (st_reg.start_time != 32'd0) && (diff > timeout_reg);
    assign go         = st_reg.commit_pending || tmo_hit;

    always_comb
    begin
        st_next  = st_reg;
        res_next = '0;
        case (stg_func_reg)
            FUNC_FIELD:
            begin
                if (stg_last_reg)
                begin
                    st_next.held_batch_id  = stg_id_reg;
                    st_next.commit_pending = 1'b1;
                end
                if (stg_drop_reg)
                begin
                    if (is_text)
                    begin
                        st_next.batch_poisoned = 1'b1;
                    end
                end
                else
                begin
                    case (stg_kind_reg)
                        KIND_TITLE: st_next.title_present = 1'b1;
                        KIND_BODY:  st_next.body_present  = 1'b1;
                        KIND_TAG:
                        begin
                            st_next.tag_pending    = 1'b1;
                            st_next.tag_rode_batch = !batch_idle;
                        end
                        default: ;
                    endcase
                end
                if (batch_idle && is_text)
                begin
                    st_next.start_time = stg_now_reg;
                end
            end
            FUNC_POLL:
            begin
                if (go)
                begin
                    res_next.resolution = st_reg.batch_poisoned ? RES_DISCARD : RES_COMMIT;
                    res_next.timed_out  = tmo_hit;
                    res_next.batch_id   = st_reg.held_batch_id;
                    if (st_reg.start_time != 32'd0)
                    begin
                        res_next.elapsed_valid = 1'b1;
                        res_next.elapsed_ms    = diff;
                    end
                    if (!st_reg.batch_poisoned)
                    begin
                        res_next.has_title = st_reg.title_present;
                        res_next.has_body  = st_reg.body_present;
                    end
                    st_next.title_present  = 1'b0;
                    st_next.body_present   = 1'b0;
                    st_next.commit_pending = 1'b0;
                    st_next.batch_poisoned = 1'b0;
                    st_next.start_time     = '0;
                    st_next.held_batch_id  = '0;
                end
                if (st_reg.tag_pending)
                begin
                    res_next.tag_in_batch  = st_reg.tag_rode_batch;
                    // drop tag state that rode a discarded batch
                    res_next.has_tag_state = !(go && st_reg.batch_poisoned
                                               && st_reg.tag_rode_batch);
                    st_next.tag_pending    = 1'b0;
                    st_next.tag_rode_batch = 1'b0;
                end
            end
            FUNC_FULL_RST:
            begin
                st_next = '0;
            end
            default:
            begin
                st_next.title_present  = 1'b0;
                st_next.body_present   = 1'b0;
                st_next.commit_pending = 1'b0;
                st_next.batch_poisoned = 1'b0;
                st_next.start_time     = '0;
                st_next.held_batch_id  = '0;
                if (st_reg.tag_rode_batch)
                begin
                    st_next.tag_pending    = 1'b0;
                    st_next.tag_rode_batch = 1'b0;
                end
            end
        endcase
    end

    // Advance the batch state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (stg_go)
        begin
            st_reg <= st_next;
        end
    end

    // Load and drain the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stg_go && stg_is_poll)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_go && stg_is_poll)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign resolution    = res_reg.resolution;
    assign timed_out     = res_reg.timed_out;
    assign batch_id      = res_reg.batch_id;
    assign elapsed_valid = res_reg.elapsed_valid;
    assign elapsed_ms    = res_reg.elapsed_ms;
    assign has_title     = res_reg.has_title;
    assign has_body      = res_reg.has_body;
    assign has_tag_state = res_reg.has_tag_state;
    assign tag_in_batch  = res_reg.tag_in_batch;

endmodule

[hw/rtl/fbct_checker.sv]
// -----------------------------------------------------------------------------
// fbct_checker
// Port-level checks on the result channel of the batch commit tracker.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbct_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  resolution,
    input logic        timed_out,
    input logic [7:0]  batch_id,
    input logic        elapsed_valid,
    input logic [31:0] elapsed_ms,
    input logic        has_title,
    input logic        has_body
);
    import fbct_pkg::*;

    // Stalled result holds
    `FBCT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(resolution) && $stable(batch_id) && $stable(elapsed_ms), "result changed while stalled")

    // No resolution means an empty result
    `FBCT_ASSERT(a_none_empty, clk, rst_n, out_valid && (resolution == RES_NONE) |-> !timed_out && (batch_id == 8'd0) && !elapsed_valid && !has_title && !has_body, "unresolved poll carries batch data")

    // Discard never reports contents
    `FBCT_ASSERT(a_discard_empty, clk, rst_n, out_valid && (resolution == RES_DISCARD) |-> !has_title && !has_body, "discard reports contents")

    // Elapsed time is zero unless flagged
    `FBCT_ASSERT(a_elapsed_zero, clk, rst_n, out_valid && !elapsed_valid |-> (elapsed_ms == 32'd0), "elapsed time without valid flag")

    // A timeout always resolves with a known code
    `FBCT_ASSERT(a_timeout_code, clk, rst_n, out_valid && timed_out |-> (resolution == RES_COMMIT) || (resolution == RES_DISCARD), "timeout without resolution")

endmodule

bind field_batch_commit_tracker_core fbct_checker u_fbct_checker (.*);
